/* rtl/core/fht_pkg.sv */
// Package for the fragment hole tracker: types, status codes and default sizes.
// Used by the controller, the datapath, the top level and the checker.
package fht_pkg;

    localparam int MAX_HOLES_DEF   = 16;
    localparam int HEADER_ROOM_DEF = 256;
    localparam logic [15:0] OFFSET_MAX = 16'hFFFF;
    localparam logic [16:0] FULL_LENGTH = 17'h10000;

    localparam logic [1:0] STATUS_WAIT  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EVAL,
        ST_RIGHT,
        ST_COMMIT,
        ST_FINAL
    } fht_state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic rd;
        logic eval;
        logic right;
        logic next;
        logic commit;
        logic report;
        logic report_err;
    } fht_cmd_t;

    typedef struct packed {
        logic pre_err;
        logic ev_err;
        logic need_right;
        logic rt_err;
        logic walk_last;
    } fht_sts_t;

endpackage

/* rtl/core/fragment_hole_tracker.sv */
// Top level of the fragment hole tracker: configuration register port, controller and datapath.
// Depends on fht_pkg, fht_ctrl and fht_dp.
//
// Usage: one fragment item is taken when start is high and busy is low. The
// block then walks its table of holes and reports one result, marked by
// result_valid for one cycle; the receiver cannot stall it.
// A fragment that fails the length or header checks is reported from the
// check state. Otherwise each held hole is walked in a read and an evaluate
// state, plus a right state when the fragment leaves a hole on its right, then
// commit and report follow; a failed hole check reports at once. The hole
// table is read one entry at a time from its single read port. The next item
// may start in the cycle result_valid is shown.
// Status is waiting, complete with the datagram length, or error. After
// complete or error the context returns to one hole covering all offsets.
// Reset clears the context and sets ipv4_mode to one; no clearing pass is
// needed. ipv4_mode is written over the APB port at byte address zero.
module fragment_hole_tracker #(
    parameter int MAX_HOLES   = fht_pkg::MAX_HOLES_DEF,
    parameter int HEADER_ROOM = fht_pkg::HEADER_ROOM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] first_offset,
    input  logic [15:0] payload_length,
    input  logic        more_fragments,
    input  logic [8:0]  link_header_length,
    input  logic [9:0]  ip_header_length,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [16:0] data_length,
    output logic [9:0]  stored_ip_header_length,
    output logic [8:0]  stored_link_header_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              ipv4_mode_reg;
    fht_pkg::fht_cmd_t cmd;
    fht_pkg::fht_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, ipv4_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            ipv4_mode_reg <= pwdata[0];
        end
    end

    fht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    fht_dp #(
        .MAX_HOLES   (MAX_HOLES),
        .HEADER_ROOM (HEADER_ROOM)
    ) u_dp (
        .clk                       (clk),
        .rst_n                     (rst_n),
        .cmd                       (cmd),
        .sts                       (sts),
        .ipv4_mode                 (ipv4_mode_reg),
        .first_offset              (first_offset),
        .payload_length            (payload_length),
        .more_fragments            (more_fragments),
        .link_header_length        (link_header_length),
        .ip_header_length          (ip_header_length),
        .result_valid              (result_valid),
        .status                    (status),
        .data_length               (data_length),
        .stored_ip_header_length   (stored_ip_header_length),
        .stored_link_header_length (stored_link_header_length)
    );

endmodule

/* rtl/core/fht_ctrl.sv */
// Controller of the fragment hole tracker: sequences the check, the hole walk and the report.
// Depends on fht_pkg.
module fht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fht_pkg::fht_sts_t sts,
    output fht_pkg::fht_cmd_t cmd
);

    fht_pkg::fht_state_t state_reg;
    fht_pkg::fht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fht_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != fht_pkg::ST_IDLE);
        unique case (state_reg)
            fht_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = fht_pkg::ST_CHECK;
                end
            end
            fht_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.pre_err)
                begin
                    cmd.report     = 1'b1;
                    cmd.report_err = 1'b1;
                    state_next     = fht_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fht_pkg::ST_READ;
                end
            end
            fht_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = fht_pkg::ST_EVAL;
            end
            fht_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (sts.ev_err)
                begin
                    cmd.report     = 1'b1;
                    cmd.report_err = 1'b1;
                    state_next     = fht_pkg::ST_IDLE;
                end
                else if (sts.need_right)
                begin
                    state_next = fht_pkg::ST_RIGHT;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = sts.walk_last ? fht_pkg::ST_COMMIT : fht_pkg::ST_READ;
                end
            end
            fht_pkg::ST_RIGHT:
            begin
                cmd.right = 1'b1;
                if (sts.rt_err)
                begin
                    cmd.report     = 1'b1;
                    cmd.report_err = 1'b1;
                    state_next     = fht_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = sts.walk_last ? fht_pkg::ST_COMMIT : fht_pkg::ST_READ;
                end
            end
            fht_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = fht_pkg::ST_FINAL;
            end
            fht_pkg::ST_FINAL:
            begin
                cmd.report = 1'b1;
                state_next = fht_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fht_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/fht_dp.sv */
// Datapath of the fragment hole tracker: item registers, ping-pong hole table and result registers.
// Depends on fht_pkg.
module fht_dp #(
    parameter int MAX_HOLES   = fht_pkg::MAX_HOLES_DEF,
    parameter int HEADER_ROOM = fht_pkg::HEADER_ROOM_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fht_pkg::fht_cmd_t cmd,
    output fht_pkg::fht_sts_t sts,
    input  logic              ipv4_mode,
    input  logic [15:0]       first_offset,
    input  logic [15:0]       payload_length,
    input  logic              more_fragments,
    input  logic [8:0]        link_header_length,
    input  logic [9:0]        ip_header_length,
    output logic              result_valid,
    output logic [1:0]        status,
    output logic [16:0]       data_length,
    output logic [9:0]        stored_ip_header_length,
    output logic [8:0]        stored_link_header_length
);

    localparam int IW    = $clog2(MAX_HOLES);
    localparam int CW    = $clog2(MAX_HOLES + 1);
    localparam int DEPTH = 2 ** (IW + 1);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;

    logic [15:0]   first_reg;
    logic [15:0]   plen_reg;
    logic          islast_reg;
    logic [8:0]    l2_reg;
    logic [9:0]    l3_reg;
    logic [15:0]   last_reg;

    logic [CW-1:0] i_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] count_reg;
    logic          bank_reg;
    logic          fresh_reg;
    logic [16:0]   dlen_reg;
    logic          known_reg;
    logic [9:0]    ip_hdr_reg;
    logic [8:0]    link_hdr_reg;

    logic          valid_reg;
    logic [1:0]    status_reg;
    logic [16:0]   dlen_out_reg;
    logic [9:0]    ip_out_reg;
    logic [8:0]    link_out_reg;

    logic [16:0]   last_sum;
    logic [10:0]   hdr_sum;
    logic          hdr_rec;
    logic [15:0]   hs;
    logic [15:0]   he;
    logic          overlap;
    logic          left;
    logic [15:0]   left_end;
    logic          left_bad;
    logic          full;
    logic          ev_push;
    logic [31:0]   ev_data;
    logic          len_rec;
    logic [17:0]   len_chk;
    logic [15:0]   right_start;
    logic          right_bad;
    logic [CW-1:0] i_inc;
    logic [16:0]   fin_dlen;
    logic [17:0]   v4_sum;
    logic [1:0]    fin_status;
    logic          wr_en;
    logic [31:0]   wr_data;

    assign last_sum    = {1'b0, first_reg} + {1'b0, plen_reg} - 17'd1;
    assign hdr_sum     = {1'b0, l3_reg} + {2'b0, l2_reg};
    assign hdr_rec     = (plen_reg != 16'd0) && !last_sum[16] && (first_reg == 16'd0);

    assign hs          = fresh_reg ? 16'd0 : rdata_reg[31:16];
    assign he          = fresh_reg ? fht_pkg::OFFSET_MAX : rdata_reg[15:0];
    assign overlap     = !((first_reg > he) || (last_reg < hs));
    assign left        = overlap && (hs < first_reg);
    assign left_end    = first_reg - 16'd1;
    assign left_bad    = (hs[2:0] != 3'd0) || (left_end[2:0] != 3'd7);
    assign full        = (n_reg >= CW'(MAX_HOLES));
    assign ev_push     = !overlap || left;
    assign ev_data     = overlap ? {hs, left_end} : {hs, he};
    assign len_rec     = overlap && islast_reg && (last_reg <= he);
    assign len_chk     = {2'b0, last_reg} + 18'd1 + {2'b0, first_reg};
    assign right_start = last_reg + 16'd1;
    assign right_bad   = full || (right_start[2:0] != 3'd0) || (he[2:0] != 3'd7);
    assign i_inc       = i_reg + CW'(1);

    assign sts.pre_err    = (plen_reg == 16'd0) || last_sum[16]
                          || (hdr_rec && (hdr_sum > 11'(HEADER_ROOM)));
    assign sts.ev_err     = (ev_push && (full || (overlap && left_bad)))
                          || (len_rec && (last_reg < he) && (len_chk > 18'd65535));
    assign sts.need_right = overlap && !islast_reg && (last_reg < he);
    assign sts.rt_err     = right_bad;
    assign sts.walk_last  = (i_inc == count_reg);

    assign fin_dlen   = known_reg ? dlen_reg : fht_pkg::FULL_LENGTH;
    assign v4_sum     = {1'b0, fin_dlen} + {8'b0, ip_hdr_reg};

    always_comb
    begin
        priority if (count_reg != '0)
        begin
            fin_status = fht_pkg::STATUS_WAIT;
        end
        else if (ipv4_mode && (v4_sum > 18'd65535))
        begin
            fin_status = fht_pkg::STATUS_ERROR;
        end
        else
        begin
            fin_status = fht_pkg::STATUS_DONE;
        end
    end

    assign wr_en   = (cmd.eval && ev_push && !full) || (cmd.right && !full);
    assign wr_data = cmd.right ? {right_start, he} : ev_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{~bank_reg, n_reg[IW-1:0]}] <= wr_data;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[{bank_reg, i_reg[IW-1:0]}];
        end
        if (cmd.load)
        begin
            first_reg  <= first_offset;
            plen_reg   <= payload_length;
            islast_reg <= !more_fragments;
            l2_reg     <= link_header_length;
            l3_reg     <= ip_header_length;
        end
        if (cmd.check)
        begin
            last_reg <= last_sum[15:0];
        end
        if (cmd.report)
        begin
            dlen_out_reg <= (!cmd.report_err && (fin_status == fht_pkg::STATUS_DONE))
                          ? fin_dlen : 17'd0;
            ip_out_reg   <= (cmd.check && hdr_rec) ? l3_reg : ip_hdr_reg;
            link_out_reg <= (cmd.check && hdr_rec) ? l2_reg : link_hdr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg        <= '0;
            n_reg        <= '0;
            count_reg    <= CW'(1);
            bank_reg     <= 1'b0;
            fresh_reg    <= 1'b1;
            dlen_reg     <= '0;
            known_reg    <= 1'b0;
            ip_hdr_reg   <= '0;
            link_hdr_reg <= '0;
            valid_reg    <= 1'b0;
            status_reg   <= fht_pkg::STATUS_WAIT;
        end
        else
        begin
            valid_reg <= cmd.report;
            if (cmd.load)
            begin
                i_reg <= '0;
                n_reg <= '0;
            end
            if (cmd.check && hdr_rec && !cmd.report)
            begin
                ip_hdr_reg   <= l3_reg;
                link_hdr_reg <= l2_reg;
            end
            if (wr_en)
            begin
                n_reg <= n_reg + CW'(1);
            end
            if (cmd.eval && len_rec && !cmd.report)
            begin
                dlen_reg  <= {1'b0, last_reg} + 17'd1;
                known_reg <= 1'b1;
            end
            if (cmd.next)
            begin
                i_reg <= i_inc;
            end
            if (cmd.commit)
            begin
                count_reg <= n_reg;
                bank_reg  <= ~bank_reg;
                fresh_reg <= 1'b0;
            end
            if (cmd.report)
            begin
                status_reg <= cmd.report_err ? fht_pkg::STATUS_ERROR : fin_status;
                if (cmd.report_err || (fin_status != fht_pkg::STATUS_WAIT))
                begin
                    count_reg    <= CW'(1);
                    fresh_reg    <= 1'b1;
                    dlen_reg     <= '0;
                    known_reg    <= 1'b0;
                    ip_hdr_reg   <= '0;
                    link_hdr_reg <= '0;
                end
            end
        end
    end

    assign result_valid              = valid_reg;
    assign status                    = status_reg;
    assign data_length               = dlen_out_reg;
    assign stored_ip_header_length   = ip_out_reg;
    assign stored_link_header_length = link_out_reg;

endmodule

/* rtl/core/fht_checker.sv */
// Port-level checker for the fragment hole tracker, bound to the top level.
// Depends on fht_pkg and fragment_hole_tracker.
module fht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  status,
    input logic [16:0] data_length
);

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Taken item did not make the block busy.");

    a_report_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("Block went idle without a result.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == fht_pkg::STATUS_WAIT) || (status == fht_pkg::STATUS_DONE)
                         || (status == fht_pkg::STATUS_ERROR))
        else $error("Result carries an unknown status.");

    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != fht_pkg::STATUS_DONE) |-> (data_length == 17'd0))
        else $error("Length reported on an incomplete result.");

endmodule

bind fragment_hole_tracker fht_checker u_fht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .data_length  (data_length)
);

/* tb/fragment_hole_tracker_tb.sv */
`timescale 1ns / 100ps
// Testbench for fragment_hole_tracker: directed and random fragment items with a
// scoreboard class that predicts hole bookkeeping. Depends on fht_pkg and the RTL.

module fragment_hole_tracker_tb;

    localparam logic [2:0] ADDR_IPV4_MODE = 3'd0;

    typedef struct {
        logic [1:0]  status;
        logic [16:0] data_length;
        logic [9:0]  ip_hdr;
        logic [8:0]  link_hdr;
    } frag_result_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    class hole_scoreboard;
        bit          ipv4_mode;
        int unsigned hs[fht_pkg::MAX_HOLES_DEF];
        int unsigned he[fht_pkg::MAX_HOLES_DEF];
        int unsigned hcount;
        int unsigned dgram_len;
        int unsigned ip_hdr;
        int unsigned link_hdr;
        bit          len_known;
        frag_result_t pending[$];

        function void clear_context();
            hs[0] = 0;
            he[0] = 65535;
            hcount = 1;
            dgram_len = 0;
            ip_hdr = 0;
            link_hdr = 0;
            len_known = 0;
        endfunction

        function new();
            ipv4_mode = 1;
            clear_context();
        endfunction

        function bit merge_fragment(int unsigned first, int unsigned last, bit final_frag);
            int unsigned ns[fht_pkg::MAX_HOLES_DEF];
            int unsigned ne[fht_pkg::MAX_HOLES_DEF];
            int unsigned n;
            int unsigned s;
            int unsigned e;
            n = 0;
            for (int i = 0; i < hcount; i++)
            begin
                s = hs[i];
                e = he[i];
                if (first > e || last < s)
                begin
                    if (n >= fht_pkg::MAX_HOLES_DEF) return 0;
                    ns[n] = s; ne[n] = e; n++;
                    continue;
                end
                if (s < first)
                begin
                    if ((s % 8) != 0 || ((first - 1) % 8) != 7
                        || n >= fht_pkg::MAX_HOLES_DEF) return 0;
                    ns[n] = s; ne[n] = first - 1; n++;
                end
                if (last < e)
                begin
                    if (!final_frag)
                    begin
                        if (((last + 1) % 8) != 0 || (e % 8) != 7
                            || n >= fht_pkg::MAX_HOLES_DEF) return 0;
                        ns[n] = last + 1; ne[n] = e; n++;
                    end
                    else
                    begin
                        dgram_len = last + 1;
                        len_known = 1;
                        if (dgram_len + first > 65535) return 0;
                    end
                end
                else if (final_frag && last == e)
                begin
                    dgram_len = last + 1;
                    len_known = 1;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                hs[i] = ns[i];
                he[i] = ne[i];
            end
            hcount = n;
            return 1;
        endfunction

        function void note_fragment(int unsigned first, int unsigned plen, bit more,
                                    int unsigned l2, int unsigned l3);
            frag_result_t r;
            bit ok;
            int unsigned last;
            int unsigned dlen;
            ok = 1;
            dlen = 0;
            r.status = fht_pkg::STATUS_WAIT;
            if (plen == 0) ok = 0;
            else
            begin
                last = first + plen - 1;
                if (last > 65535) ok = 0;
                if (ok && first == 0)
                begin
                    ip_hdr = l3;
                    link_hdr = l2;
                    if (l2 + l3 > fht_pkg::HEADER_ROOM_DEF) ok = 0;
                end
                if (ok && !merge_fragment(first, last, !more)) ok = 0;
                if (ok && hcount == 0)
                begin
                    dlen = len_known ? dgram_len : 65536;
                    if (ipv4_mode && dlen + ip_hdr > 65535)
                    begin
                        ok = 0;
                        dlen = 0;
                    end
                    else r.status = fht_pkg::STATUS_DONE;
                end
            end
            if (!ok) r.status = fht_pkg::STATUS_ERROR;
            r.data_length = dlen[16:0];
            r.ip_hdr = ip_hdr[9:0];
            r.link_hdr = link_hdr[8:0];
            pending.push_back(r);
            if (r.status != fht_pkg::STATUS_WAIT) clear_context();
        endfunction

        task check_result(frag_result_t got);
            frag_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result status", got.status, -1);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.data_length !== want.data_length)
                report_mismatch("data_length", got.data_length, want.data_length);
            if (got.ip_hdr !== want.ip_hdr)
                report_mismatch("stored_ip_header_length", got.ip_hdr, want.ip_hdr);
            if (got.link_hdr !== want.link_hdr)
                report_mismatch("stored_link_header_length", got.link_hdr, want.link_hdr);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [15:0] first_offset = 0;
    logic [15:0] payload_length = 0;
    logic        more_fragments = 0;
    logic [8:0]  link_header_length = 0;
    logic [9:0]  ip_header_length = 0;
    logic        result_valid;
    logic [1:0]  status;
    logic [16:0] data_length;
    logic [9:0]  stored_ip_header_length;
    logic [8:0]  stored_link_header_length;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    hole_scoreboard sb = new();
    bit calm = 0;

    fragment_hole_tracker uut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        frag_result_t got;
        if (rst_n && result_valid)
        begin
            got.status = status;
            got.data_length = data_length;
            got.ip_hdr = stored_ip_header_length;
            got.link_hdr = stored_link_header_length;
            sb.check_result(got);
        end
    end

    task automatic write_ipv4_mode(input bit value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_IPV4_MODE; pwdata <= {31'd0, value};
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.ipv4_mode = value;
    endtask

    task automatic send_fragment(input int unsigned first, input int unsigned plen,
                                 input int unsigned more, input int unsigned l2,
                                 input int unsigned l3);
        while (!calm && $urandom_range(99) < 19) @(posedge clk);
        @(posedge clk);
        first_offset <= first[15:0];
        payload_length <= plen[15:0];
        more_fragments <= more[0];
        link_header_length <= l2[8:0];
        ip_header_length <= l3[9:0];
        start <= 1;
        do @(posedge clk); while (busy);
        sb.note_fragment(first, plen, more[0], l2, l3);
        start <= 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (3 * fht_pkg::MAX_HOLES_DEF + 10) @(posedge clk);
    endtask

    // Covers a datagram of the given 8-byte units with fragments in random order,
    // sometimes overlapping, with random header lengths on every fragment.
    task automatic send_datagram(input int unsigned units);
        int unsigned order[$];
        int unsigned u;
        int unsigned span;
        int unsigned tmp;
        int unsigned j;
        for (int i = 0; i < units; i++) order.push_back(i);
        for (int i = units - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        foreach (order[k])
        begin
            u = order[k];
            span = ($urandom_range(3) == 0 && u + 1 < units) ? 2 : 1;
            if (u + 1 == units)
                send_fragment(u * 8, $urandom_range(1, 8), 0,
                              $urandom_range(200), $urandom_range(200));
            else
                send_fragment(u * 8, span * 8, 1, $urandom_range(511), $urandom_range(1023));
            if (sb.hcount == 1 && sb.hs[0] == 0 && sb.he[0] == 65535) break;
        end
    endtask

    initial
    begin
        #10000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: empty, past range, header room, full coverage, IPv4 check.
        send_fragment(0, 0, 1, 0, 0);
        send_fragment(65528, 16, 1, 0, 0);
        send_fragment(0, 8, 1, 200, 100);
        send_fragment(0, 8, 1, 511, 1023);
        send_fragment(0, 65535, 1, 128, 128);
        send_fragment(65535, 1, 1, 0, 0);
        send_fragment(0, 65535, 0, 0, 20);
        send_fragment(0, 65535, 1, 0, 20);
        send_fragment(65535, 1, 0, 0, 0);
        send_fragment(8, 3, 1, 0, 0);
        send_fragment(0, 16, 1, 14, 20);
        send_fragment(16, 4, 0, 0, 0);
        send_fragment(32, 8, 0, 0, 0);
        send_fragment(40, 8, 1, 0, 0);
        send_fragment(16, 24, 1, 0, 0);
        send_fragment(65000, 100, 0, 0, 0);
        for (int i = 0; i < 9; i++) send_fragment(16 * i + 8, 8, 1, 0, 0);
        send_fragment(0, 65535, 0, 0, 0);
        drain();
        write_ipv4_mode(1'b0);
        send_fragment(0, 65535, 1, 0, 256);
        send_fragment(65535, 1, 1, 0, 0);
        drain();
        write_ipv4_mode(1'b1);
        send_fragment(0, 65535, 1, 0, 256);
        send_fragment(65535, 1, 1, 0, 0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_ipv4_mode(phase[0]);
            calm = (phase == 2);
            for (int n = 0; n < 375; )
            begin
                if ($urandom_range(99) < 75)
                begin
                    send_datagram($urandom_range(1, 12));
                    n += 4;
                end
                else
                begin
                    case ($urandom_range(3))
                        0: send_fragment($urandom_range(65535), $urandom_range(65535),
                                         $urandom_range(1), $urandom_range(511),
                                         $urandom_range(1023));
                        1: send_fragment($urandom_range(8191) * 8, $urandom_range(1, 64),
                                         $urandom_range(1), $urandom_range(511),
                                         $urandom_range(1023));
                        2: send_fragment(0, $urandom_range(65535), $urandom_range(1),
                                         $urandom_range(511), $urandom_range(1023));
                        default: send_fragment(65535 - $urandom_range(15), $urandom_range(1, 16),
                                               $urandom_range(1), 0, 0);
                    endcase
                    n++;
                end
            end
            drain();
        end

        if (sb.pending.size() != 0)
            report_mismatch("missing results", sb.pending.size(), 0);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
